// ===== hw/rtl/cfir_pkg.sv =====
// ----------------------------------------------------------------------------
// cfir_pkg: shared types and constants of the complex FIR filter
// Sample, accumulator and word types, register layout and the output
// rounding and saturation function.
// ----------------------------------------------------------------------------
package cfir_pkg;

  // Field and datapath widths.
  localparam int unsigned SAMPLE_W     = 16;
  localparam int unsigned COEF_W       = 16;
  localparam int unsigned PROD_W       = SAMPLE_W + COEF_W;
  localparam int unsigned ACC_W        = 48;

  // Register file layout: four 64-bit coefficient words and one shift register.
  localparam int unsigned REG_W        = 64;
  localparam int unsigned COEF_REGS    = 4;
  localparam int unsigned COEF_PER_REG = REG_W / COEF_W;
  localparam int unsigned COEF_TOTAL   = COEF_REGS * COEF_PER_REG;
  localparam int unsigned SHIFT_W      = 6;
  localparam int unsigned ADDR_W       = 6;
  localparam int unsigned ADDR_LSB     = 3;
  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 6'd14;

  // Default filter length.
  localparam int unsigned DEFAULT_TAPS = 16;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [ACC_W-1:0]    acc_part_t;

  // One input word as it travels on the input channel.
  typedef struct packed {
    sample_t sample_re;
    sample_t sample_im;
  } in_word_t;

  // One result word as it travels on the output channel.
  typedef struct packed {
    sample_t out_re;
    sample_t out_im;
  } out_word_t;

  // A complex sample inside the filter.
  typedef struct packed {
    sample_t re;
    sample_t im;
  } cplx_t;

  // A complex partial sum handed from cell to cell.
  typedef struct packed {
    acc_part_t re;
    acc_part_t im;
  } acc_t;

  // Configuration handed from the register file to the datapath.
  typedef struct packed {
    logic [COEF_REGS-1:0][REG_W-1:0] coef;
    logic [SHIFT_W-1:0]              shift;
  } cfg_t;

  // Arithmetic right shift (floor rounding) followed by saturation to 16 bits.
  function automatic sample_t finish(input acc_part_t acc, input logic [SHIFT_W-1:0] shift);
    acc_part_t shifted;
    logic      fits;
    begin
      if (shift >= SHIFT_W'(ACC_W)) begin
        shifted = {ACC_W{acc[ACC_W-1]}};
      end else begin
        shifted = acc >>> shift;
      end
      fits = (&shifted[ACC_W-1:SAMPLE_W-1]) || ~(|shifted[ACC_W-1:SAMPLE_W-1]);
      if (fits) begin
        finish = shifted[SAMPLE_W-1:0];
      end else if (shifted[ACC_W-1]) begin
        finish = {1'b1, {(SAMPLE_W-1){1'b0}}};
      end else begin
        finish = {1'b0, {(SAMPLE_W-1){1'b1}}};
      end
    end
  endfunction

endpackage

// ===== hw/rtl/cfir_cell.sv =====
// ----------------------------------------------------------------------------
// cfir_cell: one tap of the complex FIR chain
// Holds its window sample in a skew line so that it meets the partial sum
// of the same word, multiplies it by its coefficient and adds the product
// to the sum coming from the previous cell.
// ----------------------------------------------------------------------------
module cfir_cell #(
  parameter int unsigned SKEW = 0
) (
  input  logic             clk_i,
  input  cfir_pkg::cplx_t  win_i,
  input  cfir_pkg::coef_t  coef_i,
  input  cfir_pkg::acc_t   sum_i,
  output cfir_pkg::acc_t   sum_o
);

  cfir_pkg::cplx_t samp;
  logic signed [cfir_pkg::PROD_W-1:0] prod_re_q;
  logic signed [cfir_pkg::PROD_W-1:0] prod_im_q;
  cfir_pkg::acc_t sum_q;

  // Skew line: delays the sample so that it meets the partial sum of the same word.
  if (SKEW == 0) begin : g_direct
    assign samp = win_i;
  end else begin : g_skew
    cfir_pkg::cplx_t skew_q [SKEW];

    always_ff @(posedge clk_i) begin
      skew_q[0] <= win_i;
      for (int i = 1; i < SKEW; i++) begin
        skew_q[i] <= skew_q[i-1];
      end
    end

    assign samp = skew_q[SKEW-1];
  end

  // Product stage, then accumulate stage.
  always_ff @(posedge clk_i) begin
    prod_re_q <= coef_i * samp.re;
    prod_im_q <= coef_i * samp.im;
    sum_q.re  <= sum_i.re + cfir_pkg::ACC_W'(prod_re_q);
    sum_q.im  <= sum_i.im + cfir_pkg::ACC_W'(prod_im_q);
  end

  assign sum_o = sum_q;

endmodule

// ===== hw/rtl/cfir_regs.sv =====
// ----------------------------------------------------------------------------
// cfir_regs: configuration registers of the complex FIR filter
// APB-style slave holding the four coefficient words and the output shift.
// ----------------------------------------------------------------------------
module cfir_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cfir_pkg::ADDR_W-1:0]   paddr,
  input  logic [cfir_pkg::REG_W-1:0]    pwdata,
  output logic [cfir_pkg::REG_W-1:0]    prdata,
  output logic                          pready,
  output cfir_pkg::cfg_t                cfg_o
);

  typedef enum logic [2:0] {
    REG_COEF0 = 3'd0,
    REG_COEF1 = 3'd1,
    REG_COEF2 = 3'd2,
    REG_COEF3 = 3'd3,
    REG_SHIFT = 3'd4
  } reg_idx_e;

  logic [cfir_pkg::COEF_REGS-1:0][cfir_pkg::REG_W-1:0] coef_q;
  logic [cfir_pkg::SHIFT_W-1:0] shift_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[cfir_pkg::ADDR_W-1:cfir_pkg::ADDR_LSB]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // Register writes in the access cycle; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q  <= '0;
      shift_q <= cfir_pkg::SHIFT_RESET;
    end else if (wr_en) begin
      unique case (idx)
        REG_COEF0: coef_q[0] <= pwdata;
        REG_COEF1: coef_q[1] <= pwdata;
        REG_COEF2: coef_q[2] <= pwdata;
        REG_COEF3: coef_q[3] <= pwdata;
        REG_SHIFT: shift_q   <= pwdata[cfir_pkg::SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back.
  always_comb begin
    unique case (idx)
      REG_COEF0: prdata = coef_q[0];
      REG_COEF1: prdata = coef_q[1];
      REG_COEF2: prdata = coef_q[2];
      REG_COEF3: prdata = coef_q[3];
      REG_SHIFT: prdata = cfir_pkg::REG_W'(shift_q);
      default:   prdata = '0;
    endcase
  end

  assign cfg_o.coef  = coef_q;
  assign cfg_o.shift = shift_q;

endmodule

// ===== hw/rtl/cfir_ofifo.sv =====
// ----------------------------------------------------------------------------
// cfir_ofifo: result queue of the complex FIR filter
// Stores finished words in a small memory and presents them through an
// output register to the valid/stall output channel.
// ----------------------------------------------------------------------------
module cfir_ofifo #(
  parameter int unsigned DEPTH = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  cfir_pkg::out_word_t  push_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output cfir_pkg::out_word_t  out_data_o
);

  localparam int unsigned PTR_W  = $clog2(DEPTH);
  localparam int unsigned FILL_W = $clog2(DEPTH + 1);

  cfir_pkg::out_word_t mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic              out_valid_q, out_valid_d;
  cfir_pkg::out_word_t out_data_q;
  logic              pop;

  // Refill the output register when it is empty or its word is taken.
  assign pop = (fill_q != '0) && (!out_valid_q || !out_stall_i);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({push_i, pop})
      2'b10:   fill_d = fill_q + 1'b1;
      2'b01:   fill_d = fill_q - 1'b1;
      default: fill_d = fill_q;
    endcase
    if (pop) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Pointers, fill level and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      wr_ptr_q    <= wr_ptr_d;
      rd_ptr_q    <= rd_ptr_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Queue memory with registered read into the output register.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q] <= push_data_i;
    end
    if (pop) begin
      out_data_q <= mem[rd_ptr_q];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== hw/rtl/complex_fir_16tap_unit.sv =====
// ----------------------------------------------------------------------------
// complex_fir_16tap_unit: FIR filter for complex 16-bit samples
// Direct-form filter built as a chain of TAPS cells, each one multiplying a
// skewed window sample by its real coefficient and passing the partial sum on.
//
//   Channel  Direction  Handshake                Payload
//   input    in         in_valid_i / in_stall_o  in_data_i  (sample_re, sample_im)
//   output   out        out_valid_o / out_stall_i out_data_o (out_re, out_im)
//   config   in/out     APB psel/penable/pready  paddr, pwdata, prdata (64 bits)
//
// One word is taken every cycle unless in_stall_o is high; each word gives one
// result word, which passes through the cells of the chain and then the result
// queue, a write and a registered read, before it is shown.
// Up to TAPS+4 words may be outstanding; in_stall_o rises only when all are.
// Reset clears the delay line and the control state, and loads the defaults.
// ----------------------------------------------------------------------------
module complex_fir_16tap_unit #(
  parameter int unsigned TAPS = cfir_pkg::DEFAULT_TAPS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  cfir_pkg::in_word_t           in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output cfir_pkg::out_word_t          out_data_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cfir_pkg::ADDR_W-1:0]  paddr,
  input  logic [cfir_pkg::REG_W-1:0]   pwdata,
  output logic [cfir_pkg::REG_W-1:0]   prdata,
  output logic                         pready
);

  localparam int unsigned QDEPTH = TAPS + 3;
  localparam int unsigned CAP    = QDEPTH + 1;
  localparam int unsigned CNT_W  = $clog2(CAP + 1);

  cfir_pkg::cfg_t      cfg;
  cfir_pkg::cplx_t     newest;
  cfir_pkg::cplx_t     dly_q [TAPS-1];
  cfir_pkg::acc_t      sum [TAPS+1];
  logic [TAPS:0]       vld_q;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  cfir_pkg::out_word_t fin;
  logic                accept;
  logic                deliver;

  // Register file.
  cfir_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign accept  = in_valid_i && !in_stall_o;
  assign deliver = out_valid_o && !out_stall_i;

  assign newest.re = in_data_i.sample_re;
  assign newest.im = in_data_i.sample_im;

  // Delay line of past samples; entry 0 is the most recent.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TAPS - 1; i++) begin
        dly_q[i] <= '0;
      end
    end else if (accept) begin
      dly_q[0] <= newest;
      for (int i = 1; i < TAPS - 1; i++) begin
        dly_q[i] <= dly_q[i-1];
      end
    end
  end

  assign sum[0] = '0;

  // Chain of cells: tap k takes the sample of age TAPS-1-k.
  for (genvar k = 0; k < TAPS; k++) begin : g_tap
    localparam int unsigned AGE = TAPS - 1 - k;
    cfir_pkg::cplx_t win;
    cfir_pkg::coef_t coef;

    if (AGE == 0) begin : g_new
      assign win = newest;
    end else begin : g_old
      assign win = dly_q[AGE-1];
    end

    if (k < cfir_pkg::COEF_TOTAL) begin : g_coef
      localparam int unsigned WORD = k / cfir_pkg::COEF_PER_REG;
      localparam int unsigned LANE = k % cfir_pkg::COEF_PER_REG;
      assign coef = cfg.coef[WORD][LANE*cfir_pkg::COEF_W +: cfir_pkg::COEF_W];
    end else begin : g_zero
      assign coef = '0;
    end

    cfir_cell #(
      .SKEW (k)
    ) u_cell (
      .clk_i  (clk_i),
      .win_i  (win),
      .coef_i (coef),
      .sum_i  (sum[k]),
      .sum_o  (sum[k+1])
    );
  end

  // Valid token travelling alongside the chain, and the outstanding count.
  always_comb begin
    unique case ({accept, deliver})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      cnt_q <= '0;
    end else begin
      vld_q <= {vld_q[TAPS-1:0], accept};
      cnt_q <= cnt_d;
    end
  end

  assign in_stall_o = (cnt_q == CNT_W'(CAP));

  // Shift, round and saturate the finished sums.
  assign fin.out_re = cfir_pkg::finish(sum[TAPS].re, cfg.shift);
  assign fin.out_im = cfir_pkg::finish(sum[TAPS].im, cfg.shift);

  cfir_ofifo #(
    .DEPTH (QDEPTH)
  ) u_ofifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (vld_q[TAPS]),
    .push_data_i (fin),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== hw/rtl/cfir_checker.sv =====
// ----------------------------------------------------------------------------
// cfir_checker: port-level checks of the complex FIR filter
// Watches the channels of the top level and is attached to it by bind.
// ----------------------------------------------------------------------------
module cfir_checker #(
  parameter int unsigned TAPS = cfir_pkg::DEFAULT_TAPS
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input cfir_pkg::out_word_t out_data_o
);

  localparam int unsigned PEND_W = $clog2(TAPS + 8);

  logic [PEND_W-1:0] pend_q;
  logic              acc_in;
  logic              acc_out;

  assign acc_in  = in_valid_i && !in_stall_o;
  assign acc_out = out_valid_o && !out_stall_i;

  // Words taken but not yet delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + PEND_W'(acc_in) - PEND_W'(acc_out);
    end
  end

  // A stalled result word stays valid.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  // A stalled result word keeps its value.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("result word changed while stalled");

  // With the output empty, a word appears after the cells of the chain, the queue
  // write and the registered read. A rising valid is checked against an input
  // word taken at the matching earlier edge.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(acc_in, TAPS + 3))
    else $error("result word appeared without a matching input word");

  // No result word without an outstanding input word.
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_out |-> (pend_q != '0))
    else $error("more result words than input words");

  // The input stalls only when enough words are in flight for full rate.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (pend_q >= PEND_W'(TAPS + 3)))
    else $error("input stalled with too few words outstanding");

endmodule

bind complex_fir_16tap_unit cfir_checker #(
  .TAPS (TAPS)
) u_cfir_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
